[src/ilst_pkg.sv]
`timescale 1ns / 1ps
// Shared widths, request and status codes and the cell control type for the indexed list.
package ilst_pkg;

	localparam int FUNC_W  = 3;
	localparam int POS_W   = 7;
	localparam int VAL_W   = 32;
	localparam int STAT_W  = 2;
	localparam int COUNT_W = 7;

	// Number of cell match bits combined in one first-level OR group.
	localparam int GROUP = 32;

	localparam logic [FUNC_W-1:0] FN_ADD_FRONT = 3'd0;
	localparam logic [FUNC_W-1:0] FN_ADD_BACK  = 3'd1;
	localparam logic [FUNC_W-1:0] FN_ADD_AT    = 3'd2;
	localparam logic [FUNC_W-1:0] FN_REM_FRONT = 3'd3;
	localparam logic [FUNC_W-1:0] FN_REM_BACK  = 3'd4;
	localparam logic [FUNC_W-1:0] FN_REM_AT    = 3'd5;
	localparam logic [FUNC_W-1:0] FN_FIND      = 3'd6;

	localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
	localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
	localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;
	localparam logic [STAT_W-1:0] ST_FULL  = 2'd3;

	// Command broadcast to every cell for one request.
	typedef struct packed {
		logic ld;    // a request is accepted this cycle
		logic ins;   // insert: cells above the index take their lower neighbor
		logic rem;   // remove: cells at or above the index take their upper neighbor
		logic find;  // compare the stored entry with the request value
	} cell_op_t;

endpackage

[src/ilst_if.sv]
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the request and response beats.
interface ilst_req_if
	import ilst_pkg::*;
();
	logic                     valid;
	logic                     ready;
	logic [FUNC_W-1:0]        func;
	logic [POS_W-1:0]         position;
	logic signed [VAL_W-1:0]  value;

	modport source (output valid, output func, output position, output value, input ready);
	modport sink   (input valid, input func, input position, input value, output ready);
endinterface

interface ilst_rsp_if
	import ilst_pkg::*;
();
	logic                valid;
	logic                ready;
	logic [STAT_W-1:0]   status;
	logic                found;
	logic [COUNT_W-1:0]  count;

	modport source (output valid, output status, output found, output count, input ready);
	modport sink   (input valid, input status, input found, input count, output ready);
endinterface

[src/ilst_cell.sv]
`timescale 1ns / 1ps
// One list slot: holds an entry, shifts with its neighbors and compares for a find.
module ilst_cell
	import ilst_pkg::*;
#(
	parameter int IDX = 0,
	parameter int IW  = 6,
	parameter int CW  = 7
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  cell_op_t                op,
	input  logic [IW-1:0]           idx,
	input  logic [CW-1:0]           cnt,
	input  logic signed [VAL_W-1:0] value,
	input  logic signed [VAL_W-1:0] prev_entry,
	input  logic signed [VAL_W-1:0] next_entry,
	output logic signed [VAL_W-1:0] entry,
	output logic                    match
);

	localparam logic [IW-1:0] MY_IDX = IW'(IDX);
	localparam logic [CW-1:0] MY_POS = CW'(IDX);

	logic signed [VAL_W-1:0] entry_q;
	logic                    match_q;

	always_ff @(posedge clk) begin
		if (op.ins) begin
			if (MY_IDX > idx) begin
				entry_q <= prev_entry;
			end else if (MY_IDX == idx) begin
				entry_q <= value;
			end
		end else if (op.rem) begin
			if (MY_IDX >= idx) begin
				entry_q <= next_entry;
			end
		end
	end

	// The compare sees the contents before this request's own update, which is
	// irrelevant since a find never changes the list.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q <= 1'b0;
		end else if (op.ld) begin
			match_q <= op.find && (MY_POS < cnt) && (entry_q == value);
		end
	end

	assign entry = entry_q;
	assign match = match_q;

endmodule

[src/indexed_list_insert_remove_find.sv]
`timescale 1ns / 1ps
// Top level of the indexed list: request decode, chain of cells and result pipeline.
//
// The block keeps an ordered list of up to CAPACITY signed 32-bit values.
// Requests arrive as beats on the req channel (func, position, value) and
// every request produces exactly one beat on the rsp channel (status, found,
// count), in request order.
//
// Each list slot is a cell in a row; an insert or a remove moves the cells at
// or above the index by one place toward or away from its neighbor, and a find
// compares all cells at once. The list itself is updated in the cycle the
// request beat is taken, so the next request may follow immediately: the
// block takes one request per cycle when the receiver keeps up.
//
// Pipeline: a request accepted on req passes three stages before its response
// shows on rsp: the cell row with its match bits, the registered OR of groups
// of 32 match bits, and the output register.
//
// Each stage holds when the one after it is full and stalled, so req.ready
// drops only once all three stages hold a beat behind a stalled receiver.
// Reset clears the count, the stage valid bits and the output valid; the
// stored entries are not cleared, because slots at or above the count
// never report a match.
module indexed_list_insert_remove_find
	import ilst_pkg::*;
#(
	parameter int CAPACITY = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	ilst_req_if.sink   req,
	ilst_rsp_if.source rsp
);

	localparam int CW   = $clog2(CAPACITY + 1);
	localparam int IW   = $clog2(CAPACITY);
	localparam int PW   = (CW > POS_W) ? CW : POS_W;
	localparam int NGRP = (CAPACITY + GROUP - 1) / GROUP;

	// Entry count and the handshake between the stages.
	logic [CW-1:0] cnt_q;
	logic          accept;
	logic          s1_free;
	logic          s2_free;
	logic          out_free;

	// Request decode.
	logic [PW-1:0]     cnt_w;
	logic [PW-1:0]     pos_w;
	logic [PW-1:0]     ins_pos;
	logic [PW-1:0]     rem_pos;
	logic              is_ins;
	logic              is_rem;
	logic              is_find;
	logic              do_ins;
	logic              do_rem;
	logic [STAT_W-1:0] empty_code;
	logic [STAT_W-1:0] status_d;
	logic [CW-1:0]     cnt_d;
	logic [IW-1:0]     idx_d;
	cell_op_t          op_d;

	// Cell row.
	logic signed [VAL_W-1:0] ent   [CAPACITY];
	logic [CAPACITY-1:0]     match;
	logic [NGRP-1:0]         grp_c;

	// Pipeline stages.
	logic              v_s1;
	logic [STAT_W-1:0] status_s1;
	logic [CW-1:0]     cnt_s1;
	logic              v_s2;
	logic [STAT_W-1:0] status_s2;
	logic [CW-1:0]     cnt_s2;
	logic [NGRP-1:0]   grp_s2;
	logic              rsp_v_q;
	logic [STAT_W-1:0] status_q;
	logic              found_q;
	logic [CW-1:0]     count_q;

	assign out_free  = !rsp_v_q || rsp.ready;
	assign s2_free   = !v_s2 || out_free;
	assign s1_free   = !v_s1 || s2_free;
	assign req.ready = s1_free;
	assign accept    = req.valid && s1_free;

	assign cnt_w = PW'(cnt_q);
	assign pos_w = PW'(req.position);

	// Work out what the request does to the list and which status it reports.
	// An indexed insert beyond the count is out of range even when the list is
	// full; a remove from an empty list is "empty" for front and back, but out
	// of range for an indexed remove.
	always_comb begin
		is_ins     = 1'b0;
		is_rem     = 1'b0;
		is_find    = 1'b0;
		ins_pos    = '0;
		rem_pos    = '0;
		empty_code = ST_EMPTY;
		case (req.func)
			FN_ADD_FRONT: begin
				is_ins = 1'b1;
			end
			FN_ADD_BACK: begin
				is_ins  = 1'b1;
				ins_pos = cnt_w;
			end
			FN_ADD_AT: begin
				is_ins  = 1'b1;
				ins_pos = pos_w;
			end
			FN_REM_FRONT: begin
				is_rem = 1'b1;
			end
			FN_REM_BACK: begin
				is_rem  = 1'b1;
				rem_pos = cnt_w - PW'(1);
			end
			FN_REM_AT: begin
				is_rem     = 1'b1;
				rem_pos    = pos_w;
				empty_code = ST_RANGE;
			end
			FN_FIND: begin
				is_find = 1'b1;
			end
			default: begin
			end
		endcase

		status_d = ST_DONE;
		do_ins   = 1'b0;
		do_rem   = 1'b0;
		cnt_d    = cnt_q;
		if (is_ins) begin
			if (ins_pos > cnt_w) begin
				status_d = ST_RANGE;
			end else if (cnt_w == PW'(CAPACITY)) begin
				status_d = ST_FULL;
			end else begin
				do_ins = 1'b1;
				cnt_d  = cnt_q + CW'(1);
			end
		end
		if (is_rem) begin
			if (cnt_q == '0) begin
				status_d = empty_code;
			end else if (rem_pos >= cnt_w) begin
				status_d = ST_RANGE;
			end else begin
				do_rem = 1'b1;
				cnt_d  = cnt_q - CW'(1);
			end
		end

		// A performed insert lies below the capacity and a performed remove
		// below the count, so the low bits address the cell exactly.
		idx_d = do_ins ? ins_pos[IW-1:0] : rem_pos[IW-1:0];

		op_d.ld   = accept;
		op_d.ins  = accept && do_ins;
		op_d.rem  = accept && do_rem;
		op_d.find = accept && is_find;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (accept) begin
			cnt_q <= cnt_d;
		end
	end

	// The row of cells. Each cell reads its lower neighbor for an insert and
	// its upper neighbor for a remove; the ends of the row are tied off.
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic signed [VAL_W-1:0] prev_e;
		logic signed [VAL_W-1:0] next_e;

		if (i == 0) begin : g_first
			assign prev_e = req.value;
		end else begin : g_mid_lo
			assign prev_e = ent[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign next_e = ent[i];
		end else begin : g_mid_hi
			assign next_e = ent[i+1];
		end

		ilst_cell #(
			.IDX (i),
			.IW  (IW),
			.CW  (CW)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.op         (op_d),
			.idx        (idx_d),
			.cnt        (cnt_q),
			.value      (req.value),
			.prev_entry (prev_e),
			.next_entry (next_e),
			.entry      (ent[i]),
			.match      (match[i])
		);
	end

	// First level of the match reduction: one OR per group of cells.
	for (genvar g = 0; g < NGRP; g++) begin : g_grp
		localparam int LO = g * GROUP;
		localparam int HI = ((LO + GROUP) < CAPACITY) ? (LO + GROUP - 1) : (CAPACITY - 1);
		assign grp_c[g] = |match[HI:LO];
	end

	// Stage 1 carries the status and count next to the cells' match bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s1_free) begin
			v_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_s1 <= status_d;
			cnt_s1    <= cnt_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (s2_free) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_free) begin
			status_s2 <= status_s1;
			cnt_s2    <= cnt_s1;
			grp_s2    <= grp_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_v_q <= 1'b0;
		end else if (out_free) begin
			rsp_v_q <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			status_q <= status_s2;
			found_q  <= |grp_s2;
			count_q  <= cnt_s2;
		end
	end

	assign rsp.valid  = rsp_v_q;
	assign rsp.status = status_q;
	assign rsp.found  = found_q;
	assign rsp.count  = COUNT_W'(count_q);

endmodule

[src/ilst_checker.sv]
`timescale 1ns / 1ps
// Port-level checks on the indexed list responses, bound to the top level.
module ilst_checker
	import ilst_pkg::*;
#(
	parameter int CAPACITY = 64
) (
	input logic               clk,
	input logic               arst_n,
	input logic               rsp_valid,
	input logic               rsp_ready,
	input logic [STAT_W-1:0]  rsp_status,
	input logic               rsp_found,
	input logic [COUNT_W-1:0] rsp_count
);

	localparam logic [COUNT_W-1:0] FULL_COUNT = COUNT_W'(CAPACITY);

	// A response beat held back by the receiver keeps its contents.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
			$stable(rsp_found) && $stable(rsp_count))
		else $error("response beat changed while stalled");

	// A hit is only reported for a request that completed normally.
	a_found_done: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_found |-> rsp_status == ST_DONE)
		else $error("found set with a non-done status");

	// A full status can only come from a full list.
	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status == ST_FULL |-> rsp_count == FULL_COUNT)
		else $error("full status with a count below capacity");

	// An empty status leaves the list empty.
	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status == ST_EMPTY |-> rsp_count == '0)
		else $error("empty status with a nonzero count");

endmodule

bind indexed_list_insert_remove_find ilst_checker #(
	.CAPACITY (CAPACITY)
) u_ilst_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.rsp_valid  (rsp.valid),
	.rsp_ready  (rsp.ready),
	.rsp_status (rsp.status),
	.rsp_found  (rsp.found),
	.rsp_count  (rsp.count)
);

[dv/tb_indexed_list_insert_remove_find.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the indexed list: a shadow list predicts every response beat.
module tb_indexed_list_insert_remove_find;
	import ilst_pkg::*;

	localparam int CAPACITY = 64;
	localparam int LIMIT = 400000;   // cycles, far above the slowest correct run
	localparam int RANDOM_ITEMS = 1950;
	localparam int DRAIN_CYCLES = 10;

	// The request code that the block decodes to nothing.
	localparam logic [FUNC_W-1:0] FN_UNUSED = 3'd7;

	// Traffic mixes for the random part.
	localparam int MIX_FILL   = 0;
	localparam int MIX_GROW   = 1;
	localparam int MIX_SHRINK = 2;
	localparam int MIX_MIXED  = 3;

	typedef struct {
		logic [STAT_W-1:0]  status;
		logic               found;
		logic [COUNT_W-1:0] count;
	} list_rsp_t;

	// Shadow copy of the list. Each accepted request updates it at once, in
	// acceptance order, and leaves the response it predicts in a queue; the
	// response beats from the block are compared with that queue in order.
	class list_tracker;
		logic [VAL_W-1:0] shadow_entries[$];
		list_rsp_t        pending_responses[$];
		int               errors;

		function logic [STAT_W-1:0] insert_entry(int pos, logic [VAL_W-1:0] v);
			// An index past the end is checked before fullness.
			if (pos > shadow_entries.size())
				return ST_RANGE;
			if (shadow_entries.size() >= CAPACITY)
				return ST_FULL;
			shadow_entries.insert(pos, v);
			return ST_DONE;
		endfunction

		function void note_request(logic [FUNC_W-1:0] f, logic [POS_W-1:0] p,
			logic [VAL_W-1:0] v);
			list_rsp_t r;
			int n;
			n = shadow_entries.size();
			r.status = ST_DONE;
			r.found = 1'b0;
			case (f)
			FN_ADD_FRONT: r.status = insert_entry(0, v);
			FN_ADD_BACK:  r.status = insert_entry(n, v);
			FN_ADD_AT:    r.status = insert_entry(int'(p), v);
			FN_REM_FRONT: begin
				if (n == 0)
					r.status = ST_EMPTY;
				else
					shadow_entries.delete(0);
			end
			FN_REM_BACK: begin
				if (n == 0)
					r.status = ST_EMPTY;
				else
					shadow_entries.delete(n - 1);
			end
			FN_REM_AT: begin
				// An empty list reports the index as out of range here.
				if (int'(p) >= n)
					r.status = ST_RANGE;
				else
					shadow_entries.delete(int'(p));
			end
			FN_FIND: begin
				foreach (shadow_entries[i])
					if (shadow_entries[i] == v)
						r.found = 1'b1;
			end
			default: ;
			endcase
			r.count = COUNT_W'(shadow_entries.size());
			pending_responses.push_back(r);
		endfunction

		function void check_response(logic [STAT_W-1:0] st, logic fd, logic [COUNT_W-1:0] cnt);
			list_rsp_t e;
			if (pending_responses.size() == 0) begin
				errors++;
				$display("%0t: response beat with none expected: status %0d found %0d count %0d",
					$realtime, st, fd, cnt);
				return;
			end
			e = pending_responses.pop_front();
			if (st !== e.status) begin
				errors++;
				$display("%0t: status mismatch: expected %0d actual %0d", $realtime, e.status, st);
			end
			if (fd !== e.found) begin
				errors++;
				$display("%0t: found mismatch: expected %0d actual %0d", $realtime, e.found, fd);
			end
			if (cnt !== e.count) begin
				errors++;
				$display("%0t: count mismatch: expected %0d actual %0d", $realtime, e.count, cnt);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	int   cycle_count;
	int   burst_left;
	int   items_sent;

	ilst_req_if req_ch();
	ilst_rsp_if rsp_ch();

	list_tracker tracker;

	indexed_list_insert_remove_find #(
		.CAPACITY(CAPACITY)
	) i_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch),
		.rsp   (rsp_ch)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Watchdog: a hung handshake or a lost response ends the run here.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// Every response beat is checked at the edge that takes it.
	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready)
			tracker.check_response(rsp_ch.status, rsp_ch.found, rsp_ch.count);
	end

	// The receiver switches between stall patterns in segments of random
	// length: always ready, a coin flip per cycle, mostly stalled, and a
	// fixed on/off rhythm. The always-ready segments let the block run at
	// full rate; the stalled ones fill the pipeline and push back on req.
	int rx_mode;
	int rx_left;
	int rx_phase;
	always @(negedge clk) begin
		if (rx_left == 0) begin
			rx_mode <= $urandom_range(0, 3);
			rx_left <= $urandom_range(10, 80);
			rx_phase <= 0;
		end else begin
			rx_left <= rx_left - 1;
			rx_phase <= rx_phase + 1;
			case (rx_mode)
			0: rsp_ch.ready <= 1'b1;
			1: rsp_ch.ready <= $urandom_range(0, 1);
			2: rsp_ch.ready <= ($urandom_range(0, 4) == 0);
			default: rsp_ch.ready <= (rx_phase % 5) < 2;
			endcase
		end
	end

	// Offers one request beat from a falling edge and returns at the falling
	// edge after it was taken. Valid stays high, so back-to-back beats go out
	// with no bubble when the caller sends again at once.
	task automatic send(input logic [FUNC_W-1:0] f, input logic [POS_W-1:0] p,
		input logic [VAL_W-1:0] v);
		req_ch.valid <= 1'b1;
		req_ch.func <= f;
		req_ch.position <= p;
		req_ch.value <= v;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		tracker.note_request(f, p, v);
		if (f != FN_UNUSED)
			items_sent++;
		@(negedge clk);
	endtask

	task automatic idle(input int n);
		req_ch.valid <= 1'b0;
		repeat (n) @(negedge clk);
	endtask

	// Sender pacing: bursts of random length with a random gap between them.
	task automatic pace();
		if (burst_left == 0) begin
			if ($urandom_range(0, 2) != 0)
				idle($urandom_range(1, 6));
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
	endtask

	task automatic wait_for_drain();
		idle(1);
		while (tracker.pending_responses.size() != 0)
			@(negedge clk);
	endtask

	// Values: a small pool gives duplicates and find hits, a stored value
	// gives hits on arbitrary data, and a full random word reaches every bit.
	function automatic logic [VAL_W-1:0] pick_value();
		int r;
		int n;
		r = $urandom_range(0, 9);
		n = tracker.shadow_entries.size();
		if (r < 3 && n > 0)
			return tracker.shadow_entries[$urandom_range(0, n - 1)];
		if (r < 6)
			return VAL_W'($urandom_range(0, 16) - 8);
		return $urandom;
	endfunction

	task automatic random_request(input int mix);
		logic [FUNC_W-1:0] f;
		logic [POS_W-1:0]  p;
		int r;
		int n;
		int add_w;
		int find_w;
		n = tracker.shadow_entries.size();
		case (mix)
		MIX_FILL:   begin add_w = 99; find_w = 0; end
		MIX_GROW:   begin add_w = 65; find_w = 15; end
		MIX_SHRINK: begin add_w = 25; find_w = 15; end
		default:    begin add_w = 45; find_w = 15; end
		endcase
		r = $urandom_range(0, 99);
		if (r < 1 && mix != MIX_FILL)
			f = FN_UNUSED;
		else if (r < 1 + add_w)
			f = FN_ADD_FRONT + FUNC_W'($urandom_range(0, 2));
		else if (r < 1 + add_w + find_w)
			f = FN_FIND;
		else
			f = FN_REM_FRONT + FUNC_W'($urandom_range(0, 2));
		// Positions mostly stay in range; a tenth go anywhere in 0..64.
		p = POS_W'($urandom_range(0, 64));
		if (f == FN_ADD_AT && $urandom_range(0, 9) != 0)
			p = POS_W'($urandom_range(0, n));
		if (f == FN_REM_AT && n > 0 && $urandom_range(0, 9) != 0)
			p = POS_W'($urandom_range(0, n - 1));
		pace();
		send(f, p, pick_value());
	endtask

	initial begin
		int mix;
		int phase_len;
		tracker = new();
		cycle_count = 0;
		burst_left = 0;
		items_sent = 0;
		rx_mode = 0;
		rx_left = 0;
		rx_phase = 0;
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.func = FN_ADD_FRONT;
		req_ch.position = '0;
		req_ch.value = '0;
		rsp_ch.ready = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed part. Start on the empty list: removals and an insert past
		// the end are all refused, and a find sees nothing.
		send(FN_REM_FRONT, '0, '0);
		send(FN_REM_BACK, '0, '0);
		send(FN_REM_AT, '0, '0);
		send(FN_FIND, '0, '0);
		send(FN_ADD_AT, 7'd1, 32'd5);
		// Extremes of the value, inserted through every add operation.
		send(FN_ADD_FRONT, 7'd127, 32'h8000_0000);
		send(FN_ADD_BACK, '0, 32'h7fff_ffff);
		send(FN_ADD_AT, 7'd1, 32'hffff_ffff);
		send(FN_ADD_AT, 7'd3, 32'h0000_0000);
		send(FN_FIND, '0, 32'h8000_0000);
		send(FN_FIND, '0, 32'h7fff_fffe);
		send(FN_FIND, 7'd64, 32'hffff_ffff);
		// The unused code must leave the list alone.
		send(FN_UNUSED, 7'd127, 32'h5555_aaaa);
		// Remove at an index equal to the count, and far past it.
		send(FN_REM_AT, 7'd4, '0);
		send(FN_REM_AT, 7'd64, '0);
		send(FN_REM_AT, 7'd1, '0);
		send(FN_FIND, '0, 32'hffff_ffff);
		send(FN_REM_BACK, '0, '0);
		send(FN_REM_FRONT, '0, '0);
		send(FN_REM_FRONT, '0, '0);
		send(FN_FIND, '0, 32'h7fff_ffff);
		wait_for_drain();

		// Fill the list to capacity with random inserts, then knock on the
		// full list with every add operation, including one at the very end.
		while (tracker.shadow_entries.size() < CAPACITY)
			random_request(MIX_FILL);
		send(FN_ADD_FRONT, '0, $urandom);
		send(FN_ADD_BACK, '0, $urandom);
		send(FN_ADD_AT, 7'd64, $urandom);
		send(FN_ADD_AT, POS_W'($urandom_range(0, 63)), $urandom);
		send(FN_FIND, '0, pick_value());
		send(FN_REM_AT, 7'd63, '0);
		send(FN_ADD_AT, 7'd65, $urandom);

		// Random part: phases that drift the count up, down or sideways, so
		// the list keeps sweeping between empty and full.
		while (items_sent < RANDOM_ITEMS) begin
			mix = $urandom_range(MIX_GROW, MIX_MIXED);
			phase_len = $urandom_range(20, 120);
			repeat (phase_len)
				random_request(mix);
			if ($urandom_range(0, 7) == 0)
				wait_for_drain();
		end

		wait_for_drain();
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (tracker.errors == 0 && tracker.pending_responses.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

[sim.f]
src/ilst_pkg.sv
src/ilst_if.sv
src/ilst_cell.sv
src/indexed_list_insert_remove_find.sv
src/ilst_checker.sv
dv/tb_indexed_list_insert_remove_find.sv
